>>> hdl/rgb2hsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; compile first.
package rgb2hsv_pkg;

  localparam int HUE_W      = 15;
  localparam int HUE_SUM_W  = 16;
  localparam int HUE_QUOT_W = 12;

  // 3840 = 4096 - 256, hue quotient scale for sixty degrees
  localparam int HUE_MUL_HI_SH = 12;
  localparam int HUE_MUL_LO_SH = 8;

  localparam logic signed [HUE_SUM_W-1:0] HUE_BASE_RED   = 16'sd0;
  localparam logic signed [HUE_SUM_W-1:0] HUE_BASE_GREEN = 16'sd7680;
  localparam logic signed [HUE_SUM_W-1:0] HUE_BASE_BLUE  = 16'sd15360;
  localparam logic signed [HUE_SUM_W-1:0] HUE_FULL       = 16'sd23040;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    sector_e sector;
    logic    neg;
    logic    gray;
  } hue_ctl_t;

endpackage

>>> hdl/rgb2hsv_pix_if.sv
// Pixel input channel: valid/ready handshake carrying one RGB word.
// Depends on nothing.
interface rgb2hsv_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

>>> hdl/rgb2hsv_hsv_if.sv
// Result channel: valid/ready handshake carrying one HSV word.
// Depends on rgb2hsv_pkg.
interface rgb2hsv_hsv_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                           valid;
  logic                           ready;
  logic [rgb2hsv_pkg::HUE_W-1:0]  hue_out;
  logic [CHANNEL_BITS-1:0]        saturation_out;
  logic [CHANNEL_BITS-1:0]        value_out;

  modport source (output valid, output hue_out, output saturation_out, output value_out,
                  input ready);
  modport sink   (input valid, input hue_out, input saturation_out, input value_out,
                  output ready);
endinterface

>>> hdl/rgb_to_hsv_converter_core.sv
// RGB to HSV converter, top level: prep, bit-per-stage divider and post.
// Throughput: one word per cycle unless stalled; every stage holds under
// back-pressure and fills bubbles, so input is taken while a result waits
// at the output until every stage is full.
// Reset (rst_ni low, asynchronous) clears all stage valid bits only.
// Depends on rgb2hsv_pkg, rgb2hsv_pix_if, rgb2hsv_hsv_if, prep, div, post.
module rgb_to_hsv_converter_core #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgb2hsv_pix_if.sink          pix_i,
  rgb2hsv_hsv_if.source        hsv_o
);

  localparam int QuotBits = (CHANNEL_BITS > rgb2hsv_pkg::HUE_QUOT_W) ?
                            CHANNEL_BITS : rgb2hsv_pkg::HUE_QUOT_W;
  localparam int DivW     = CHANNEL_BITS + QuotBits;

  logic                              pd_valid;
  logic                              pd_ready;
  logic [CHANNEL_BITS-1:0]           pd_value;
  logic [CHANNEL_BITS-1:0]           pd_delta;
  rgb2hsv_pkg::hue_ctl_t             pd_ctl;
  logic [DivW-1:0]                   pd_dvd_sat;
  logic [DivW-1:0]                   pd_dvd_hue;

  logic                              dp_valid;
  logic                              dp_ready;
  logic [CHANNEL_BITS-1:0]           dp_value;
  rgb2hsv_pkg::hue_ctl_t             dp_ctl;
  logic [CHANNEL_BITS-1:0]           dp_quot_sat;
  logic [rgb2hsv_pkg::HUE_QUOT_W-1:0] dp_quot_hue;

  rgb2hsv_prep #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .DIV_W        (DivW)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .red_i       (pix_i.red_in),
    .green_i     (pix_i.green_in),
    .blue_i      (pix_i.blue_in),
    .out_valid_o (pd_valid),
    .out_ready_i (pd_ready),
    .value_o     (pd_value),
    .delta_o     (pd_delta),
    .ctl_o       (pd_ctl),
    .dvd_sat_o   (pd_dvd_sat),
    .dvd_hue_o   (pd_dvd_hue)
  );

  rgb2hsv_div #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .QUOT_BITS    (QuotBits),
    .DIV_W        (DivW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pd_valid),
    .in_ready_o  (pd_ready),
    .value_i     (pd_value),
    .delta_i     (pd_delta),
    .ctl_i       (pd_ctl),
    .dvd_sat_i   (pd_dvd_sat),
    .dvd_hue_i   (pd_dvd_hue),
    .out_valid_o (dp_valid),
    .out_ready_i (dp_ready),
    .value_o     (dp_value),
    .ctl_o       (dp_ctl),
    .quot_sat_o  (dp_quot_sat),
    .quot_hue_o  (dp_quot_hue)
  );

  rgb2hsv_post #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dp_valid),
    .in_ready_o  (dp_ready),
    .value_i     (dp_value),
    .ctl_i       (dp_ctl),
    .quot_sat_i  (dp_quot_sat),
    .quot_hue_i  (dp_quot_hue),
    .out_valid_o (hsv_o.valid),
    .out_ready_i (hsv_o.ready),
    .hue_o       (hsv_o.hue_out),
    .sat_o       (hsv_o.saturation_out),
    .value_o     (hsv_o.value_out)
  );

endmodule

>>> hdl/rgb2hsv_prep.sv
// Front end: max/min/sector selection, then dividend forming (two stages).
// Depends on rgb2hsv_pkg.
module rgb2hsv_prep #(
  parameter int CHANNEL_BITS = 8,
  parameter int DIV_W        = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CHANNEL_BITS-1:0] value_o,
  output logic [CHANNEL_BITS-1:0] delta_o,
  output rgb2hsv_pkg::hue_ctl_t   ctl_o,
  output logic [DIV_W-1:0]        dvd_sat_o,
  output logic [DIV_W-1:0]        dvd_hue_o
);

  logic                    en_a;
  logic                    en_b;
  logic [CHANNEL_BITS-1:0] hi_d;
  logic [CHANNEL_BITS-1:0] lo_d;
  logic [CHANNEL_BITS-1:0] dx;
  logic [CHANNEL_BITS-1:0] dy;
  logic [CHANNEL_BITS-1:0] mag_d;
  logic [CHANNEL_BITS-1:0] delta_d;
  rgb2hsv_pkg::hue_ctl_t   ctl_d;

  logic                    a_vld_q;
  logic [CHANNEL_BITS-1:0] a_value_q;
  logic [CHANNEL_BITS-1:0] a_delta_q;
  logic [CHANNEL_BITS-1:0] a_mag_q;
  rgb2hsv_pkg::hue_ctl_t   a_ctl_q;

  logic                    b_vld_q;
  logic [CHANNEL_BITS-1:0] b_value_q;
  logic [CHANNEL_BITS-1:0] b_delta_q;
  rgb2hsv_pkg::hue_ctl_t   b_ctl_q;
  logic [DIV_W-1:0]        b_dvd_sat_q;
  logic [DIV_W-1:0]        b_dvd_hue_q;
  logic [DIV_W-1:0]        dvd_sat_d;
  logic [DIV_W-1:0]        dvd_hue_d;

  assign en_b       = !b_vld_q || out_ready_i;
  assign en_a       = !a_vld_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      ctl_d.sector = rgb2hsv_pkg::SECT_RED;
      hi_d         = red_i;
      dx           = green_i;
      dy           = blue_i;
    end else if (green_i >= blue_i) begin
      ctl_d.sector = rgb2hsv_pkg::SECT_GREEN;
      hi_d         = green_i;
      dx           = blue_i;
      dy           = red_i;
    end else begin
      ctl_d.sector = rgb2hsv_pkg::SECT_BLUE;
      hi_d         = blue_i;
      dx           = red_i;
      dy           = green_i;
    end
    lo_d = red_i;
    if (green_i < lo_d) lo_d = green_i;
    if (blue_i < lo_d) lo_d = blue_i;
    delta_d    = hi_d - lo_d;
    ctl_d.neg  = dx < dy;
    mag_d      = ctl_d.neg ? (dy - dx) : (dx - dy);
    ctl_d.gray = delta_d == '0;
  end

  assign dvd_sat_d = (DIV_W'(a_delta_q) << CHANNEL_BITS) - DIV_W'(a_delta_q);
  assign dvd_hue_d = (DIV_W'(a_mag_q) << rgb2hsv_pkg::HUE_MUL_HI_SH)
                   - (DIV_W'(a_mag_q) << rgb2hsv_pkg::HUE_MUL_LO_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= in_valid_i;
      if (en_b) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      a_value_q <= hi_d;
      a_delta_q <= delta_d;
      a_mag_q   <= mag_d;
      a_ctl_q   <= ctl_d;
    end
    if (en_b && a_vld_q) begin
      b_value_q   <= a_value_q;
      b_delta_q   <= a_delta_q;
      b_ctl_q     <= a_ctl_q;
      b_dvd_sat_q <= dvd_sat_d;
      b_dvd_hue_q <= dvd_hue_d;
    end
  end

  assign out_valid_o = b_vld_q;
  assign value_o     = b_value_q;
  assign delta_o     = b_delta_q;
  assign ctl_o       = b_ctl_q;
  assign dvd_sat_o   = b_dvd_sat_q;
  assign dvd_hue_o   = b_dvd_hue_q;

endmodule

>>> hdl/rgb2hsv_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Lane S: saturation (divisor = value); lane H: hue (divisor = delta). Depends on rgb2hsv_pkg.
module rgb2hsv_div #(
  parameter int CHANNEL_BITS = 8,
  parameter int QUOT_BITS    = 12,
  parameter int DIV_W        = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CHANNEL_BITS-1:0] value_i,
  input  logic [CHANNEL_BITS-1:0] delta_i,
  input  rgb2hsv_pkg::hue_ctl_t   ctl_i,
  input  logic [DIV_W-1:0]        dvd_sat_i,
  input  logic [DIV_W-1:0]        dvd_hue_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CHANNEL_BITS-1:0] value_o,
  output rgb2hsv_pkg::hue_ctl_t   ctl_o,
  output logic [CHANNEL_BITS-1:0]             quot_sat_o,
  output logic [rgb2hsv_pkg::HUE_QUOT_W-1:0] quot_hue_o
);

  logic [QUOT_BITS:0]      en;
  logic [QUOT_BITS-1:0]    vld_q;
  logic [QUOT_BITS-1:0]    src_vld;

  logic [CHANNEL_BITS-1:0] value_q   [QUOT_BITS];
  logic [CHANNEL_BITS-1:0] delta_q   [QUOT_BITS];
  rgb2hsv_pkg::hue_ctl_t   ctl_q     [QUOT_BITS];
  logic [DIV_W-1:0]        rem_s_q   [QUOT_BITS];
  logic [DIV_W-1:0]        rem_h_q   [QUOT_BITS];
  logic [QUOT_BITS-1:0]    quot_s_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0]    quot_h_q  [QUOT_BITS];

  logic [CHANNEL_BITS-1:0] src_value [QUOT_BITS];
  logic [CHANNEL_BITS-1:0] src_delta [QUOT_BITS];
  rgb2hsv_pkg::hue_ctl_t   src_ctl   [QUOT_BITS];
  logic [DIV_W-1:0]        src_rem_s [QUOT_BITS];
  logic [DIV_W-1:0]        src_rem_h [QUOT_BITS];
  logic [QUOT_BITS-1:0]    src_quot_s[QUOT_BITS];
  logic [QUOT_BITS-1:0]    src_quot_h[QUOT_BITS];

  assign en[QUOT_BITS] = out_ready_i;
  assign in_ready_o    = en[0];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    localparam int Sh = QUOT_BITS - 1 - k;

    logic [DIV_W-1:0] dsr_s;
    logic [DIV_W-1:0] dsr_h;
    logic             bit_s;
    logic             bit_h;
    logic [DIV_W-1:0] rem_s_d;
    logic [DIV_W-1:0] rem_h_d;

    if (k == 0) begin : g_first
      assign src_vld[k]    = in_valid_i;
      assign src_value[k]  = value_i;
      assign src_delta[k]  = delta_i;
      assign src_ctl[k]    = ctl_i;
      assign src_rem_s[k]  = dvd_sat_i;
      assign src_rem_h[k]  = dvd_hue_i;
      assign src_quot_s[k] = '0;
      assign src_quot_h[k] = '0;
    end else begin : g_next
      assign src_vld[k]    = vld_q[k-1];
      assign src_value[k]  = value_q[k-1];
      assign src_delta[k]  = delta_q[k-1];
      assign src_ctl[k]    = ctl_q[k-1];
      assign src_rem_s[k]  = rem_s_q[k-1];
      assign src_rem_h[k]  = rem_h_q[k-1];
      assign src_quot_s[k] = quot_s_q[k-1];
      assign src_quot_h[k] = quot_h_q[k-1];
    end

    assign en[k]   = !vld_q[k] || en[k+1];
    assign dsr_s   = DIV_W'(src_value[k]) << Sh;
    assign dsr_h   = DIV_W'(src_delta[k]) << Sh;
    assign bit_s   = src_rem_s[k] >= dsr_s;
    assign bit_h   = src_rem_h[k] >= dsr_h;
    assign rem_s_d = bit_s ? (src_rem_s[k] - dsr_s) : src_rem_s[k];
    assign rem_h_d = bit_h ? (src_rem_h[k] - dsr_h) : src_rem_h[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && src_vld[k]) begin
        value_q[k]  <= src_value[k];
        delta_q[k]  <= src_delta[k];
        ctl_q[k]    <= src_ctl[k];
        rem_s_q[k]  <= rem_s_d;
        rem_h_q[k]  <= rem_h_d;
        quot_s_q[k] <= {src_quot_s[k][QUOT_BITS-2:0], bit_s};
        quot_h_q[k] <= {src_quot_h[k][QUOT_BITS-2:0], bit_h};
      end
    end
  end

  assign out_valid_o = vld_q[QUOT_BITS-1];
  assign value_o     = value_q[QUOT_BITS-1];
  assign ctl_o       = ctl_q[QUOT_BITS-1];
  assign quot_sat_o  = quot_s_q[QUOT_BITS-1][CHANNEL_BITS-1:0];
  assign quot_hue_o  = quot_h_q[QUOT_BITS-1][rgb2hsv_pkg::HUE_QUOT_W-1:0];

endmodule

>>> hdl/rgb2hsv_post.sv
// Back end: sector offset, sign, wrap into one turn, output register.
// Depends on rgb2hsv_pkg.
module rgb2hsv_post #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [CHANNEL_BITS-1:0]           value_i,
  input  rgb2hsv_pkg::hue_ctl_t             ctl_i,
  input  logic [CHANNEL_BITS-1:0]           quot_sat_i,
  input  logic [rgb2hsv_pkg::HUE_QUOT_W-1:0] quot_hue_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rgb2hsv_pkg::HUE_W-1:0]     hue_o,
  output logic [CHANNEL_BITS-1:0]           sat_o,
  output logic [CHANNEL_BITS-1:0]           value_o
);

  logic                                   vld_q;
  logic                                   en;
  logic signed [rgb2hsv_pkg::HUE_SUM_W-1:0] base;
  logic signed [rgb2hsv_pkg::HUE_SUM_W-1:0] quot;
  logic signed [rgb2hsv_pkg::HUE_SUM_W-1:0] sum;
  logic signed [rgb2hsv_pkg::HUE_SUM_W-1:0] wrapped;
  logic [rgb2hsv_pkg::HUE_W-1:0]          hue_d;
  logic [CHANNEL_BITS-1:0]                sat_d;
  logic [rgb2hsv_pkg::HUE_W-1:0]          hue_q;
  logic [CHANNEL_BITS-1:0]                sat_q;
  logic [CHANNEL_BITS-1:0]                value_q;

  assign en         = !vld_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    case (ctl_i.sector)
      rgb2hsv_pkg::SECT_RED:   base = rgb2hsv_pkg::HUE_BASE_RED;
      rgb2hsv_pkg::SECT_GREEN: base = rgb2hsv_pkg::HUE_BASE_GREEN;
      rgb2hsv_pkg::SECT_BLUE:  base = rgb2hsv_pkg::HUE_BASE_BLUE;
      default:                 base = rgb2hsv_pkg::HUE_BASE_RED;
    endcase
    quot = signed'(rgb2hsv_pkg::HUE_SUM_W'(quot_hue_i));
    sum  = ctl_i.neg ? (base - quot) : (base + quot);
    if (sum < 0) begin
      wrapped = sum + rgb2hsv_pkg::HUE_FULL;
    end else if (sum >= rgb2hsv_pkg::HUE_FULL) begin
      wrapped = sum - rgb2hsv_pkg::HUE_FULL;
    end else begin
      wrapped = sum;
    end
    hue_d = ctl_i.gray ? '0 : wrapped[rgb2hsv_pkg::HUE_W-1:0];
    sat_d = ctl_i.gray ? '0 : quot_sat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= value_i;
    end
  end

  assign out_valid_o = vld_q;
  assign hue_o       = hue_q;
  assign sat_o       = sat_q;
  assign value_o     = value_q;

endmodule

>>> bench/tb.sv
// Testbench for rgb_to_hsv_converter_core: random and corner-case pixels are
// streamed in, and every HSV word is checked against an in-bench predictor.
// Depends on rgb2hsv_pkg, rgb2hsv_pix_if, rgb2hsv_hsv_if and the core.
module tb;
  import rgb2hsv_pkg::*;

  localparam int CH_W        = 8;
  localparam int CMAX        = (1 << CH_W) - 1;
  localparam int SIXTY_DEG   = 3840;
  localparam int FULL_TURN   = 23040;
  localparam int RAND_ITEMS  = 1730;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYC   = 40;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_t;

  localparam int N_CORNER = 20;
  localparam pixel_t CORNER_PIX [N_CORNER] = '{
    {8'd0,   8'd0,   8'd0},
    {8'd255, 8'd255, 8'd255},
    {8'd128, 8'd128, 8'd128},
    {8'd255, 8'd0,   8'd0},
    {8'd0,   8'd255, 8'd0},
    {8'd0,   8'd0,   8'd255},
    {8'd255, 8'd255, 8'd0},
    {8'd0,   8'd255, 8'd255},
    {8'd255, 8'd0,   8'd255},
    {8'd255, 8'd0,   8'd1},
    {8'd255, 8'd1,   8'd0},
    {8'd1,   8'd0,   8'd0},
    {8'd0,   8'd1,   8'd255},
    {8'd1,   8'd255, 8'd0},
    {8'd1,   8'd1,   8'd0},
    {8'd200, 8'd100, 8'd50},
    {8'd50,  8'd200, 8'd100},
    {8'd100, 8'd50,  8'd200},
    {8'd255, 8'd255, 8'd254},
    {8'd1,   8'd0,   8'd1}
  };
  localparam int PIX_TOTAL = N_CORNER + RAND_ITEMS;

  logic clk;
  logic rst_n;

  rgb2hsv_pix_if #(.CHANNEL_BITS(CH_W)) pix ();
  rgb2hsv_hsv_if #(.CHANNEL_BITS(CH_W)) hsv ();

  rgb_to_hsv_converter_core #(.CHANNEL_BITS(CH_W)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix.sink),
    .hsv_o  (hsv.source)
  );

  pixel_t pix_q[$];
  hsv_t   hsv_exp_q[$];
  pixel_t next_pix;
  hsv_t   got_hsv;
  hsv_t   want_hsv;
  logic   pix_taken;
  logic   hsv_taken;
  logic   send_calm;
  logic   recv_calm;
  logic   choke;
  int     send_wait;
  int     recv_wait;
  int     pix_sent;
  int     err_cnt;
  int     cycle_cnt;

  function automatic hsv_t predict_hsv(pixel_t px);
    int      r;
    int      g;
    int      b;
    int      hi;
    int      lo;
    int      span;
    int      diff;
    int      base;
    int      hue_v;
    sector_e sect;
    hsv_t    res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    res = '0;
    res.val = hi[CH_W-1:0];
    if (span != 0) begin
      res.sat = CH_W'((span * CMAX) / hi);
      if (r == hi) sect = SECT_RED;
      else if (g == hi) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED: begin
          base = 0;
          diff = g - b;
        end
        SECT_GREEN: begin
          base = 2 * SIXTY_DEG;
          diff = b - r;
        end
        default: begin
          base = 4 * SIXTY_DEG;
          diff = r - g;
        end
      endcase
      hue_v = base + (SIXTY_DEG * diff) / span;
      if (hue_v < 0) hue_v += FULL_TURN;
      if (hue_v >= FULL_TURN) hue_v -= FULL_TURN;
      res.hue = hue_v[HUE_W-1:0];
    end
    return res;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int     pick;
    logic [CH_W-1:0] grey;
    pick = $urandom_range(0, 9);
    px.red   = CH_W'($urandom);
    px.green = CH_W'($urandom);
    px.blue  = CH_W'($urandom);
    if (pick == 6 || pick == 7) begin
      grey = CH_W'($urandom);
      px.red   = grey ^ CH_W'($urandom_range(0, 3));
      px.green = grey ^ CH_W'($urandom_range(0, 3));
      px.blue  = grey ^ CH_W'($urandom_range(0, 3));
    end else if (pick >= 8) begin
      case ($urandom_range(0, 4))
        0: px.green = px.red;
        1: px.blue = px.red;
        2: px.blue = px.green;
        3: px.red = CH_W'(CMAX);
        default: px.green = '0;
      endcase
    end
    return px;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: offer the next word once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (pix_taken || !pix.valid) begin
      if (send_wait > 0) begin
        send_wait--;
        pix.valid <= 1'b0;
      end else if (pix_q.size() > 0) begin
        next_pix = pix_q.pop_front();
        pix.valid    <= 1'b1;
        pix.red_in   <= next_pix.red;
        pix.green_in <= next_pix.green;
        pix.blue_in  <= next_pix.blue;
        send_wait = (send_calm || choke) ? 0 : $urandom_range(0, 9);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      hsv.ready <= 1'b0;
    end else begin
      if (hsv_taken) recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
      if (choke) begin
        hsv.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        hsv.ready <= 1'b0;
      end else begin
        hsv.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted pixels, check accepted results
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_taken <= 1'b0;
      hsv_taken <= 1'b0;
    end else begin
      cycle_cnt++;
      pix_taken <= pix.valid && pix.ready;
      hsv_taken <= hsv.valid && hsv.ready;
      if (pix.valid && pix.ready) begin
        hsv_exp_q.push_back(predict_hsv({pix.red_in, pix.green_in, pix.blue_in}));
        pix_sent++;
      end
      if (hsv.valid && hsv.ready) begin
        got_hsv = {hsv.hue_out, hsv.saturation_out, hsv.value_out};
        if (hsv_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("tb: unexpected word hue %0d sat %0d val %0d",
                     got_hsv.hue, got_hsv.sat, got_hsv.val);
        end else begin
          want_hsv = hsv_exp_q.pop_front();
          if (got_hsv !== want_hsv) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("tb: mismatch hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/got)",
                       want_hsv.hue, got_hsv.hue, want_hsv.sat, got_hsv.sat,
                       want_hsv.val, got_hsv.val);
          end
        end
      end
    end
  end

  initial begin
    send_calm = 1'b0;
    recv_calm = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      send_calm = ($urandom_range(0, 2) == 0);
      recv_calm = ($urandom_range(0, 2) == 0);
    end
  end

  // hold the result side off long enough for the pipeline to back up
  initial begin
    choke = 1'b0;
    while (pix_sent < 300) @(negedge clk);
    choke <= 1'b1;
    repeat (400) @(negedge clk);
    choke <= 1'b0;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    pix.valid    = 1'b0;
    pix.red_in   = '0;
    pix.green_in = '0;
    pix.blue_in  = '0;
    hsv.ready    = 1'b0;
    send_wait    = 0;
    recv_wait    = 0;
    pix_sent     = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    for (int i = 0; i < N_CORNER; i++) pix_q.push_back(CORNER_PIX[i]);
    for (int i = 0; i < RAND_ITEMS; i++) pix_q.push_back(rand_pixel());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pix_sent < PIX_TOTAL) @(posedge clk);
    while (hsv_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rgb2hsv_pkg.sv
hdl/rgb2hsv_pix_if.sv
hdl/rgb2hsv_hsv_if.sv
hdl/rgb2hsv_prep.sv
hdl/rgb2hsv_div.sv
hdl/rgb2hsv_post.sv
hdl/rgb_to_hsv_converter_core.sv
bench/tb.sv
